/* sv/lpr_pkg.sv */
`timescale 1ns / 1ps
// Shared constants and types for the LRU page replacement core.
// No dependencies; imported by every module of the block.
package lpr_pkg;

  localparam int MAX_FRAMES   = 16;
  localparam int PAGE_BITS    = 16;
  localparam int FRAME_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int RANK_W       = FRAME_W;
  localparam int CNT_W        = $clog2(MAX_FRAMES + 1);
  localparam int CFG_W        = 5;
  localparam int PAGE_IN_W    = 16;
  localparam int FRAME_OUT_W  = 4;
  localparam int FAULT_W      = 32;

  localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(16);

  typedef struct packed {
    logic               touch_en;
    logic               set_valid;
    logic [FRAME_W-1:0] frame;
    logic [CNT_W-1:0]   old_rank;
  } rank_ctl_t;

endpackage

/* sv/lpr_page_mem.sv */
`timescale 1ns / 1ps
// Page number store, one entry per frame, with a registered read port.
// Depends on lpr_pkg for the frame count and page width.
module lpr_page_mem (
  input  logic                          clk,
  input  logic                          we,
  input  logic [lpr_pkg::FRAME_W-1:0]   waddr,
  input  logic [lpr_pkg::PAGE_BITS-1:0] wdata,
  input  logic [lpr_pkg::FRAME_W-1:0]   raddr,
  output logic [lpr_pkg::PAGE_BITS-1:0] rdata
);
  import lpr_pkg::*;

  logic [PAGE_BITS-1:0] mem [MAX_FRAMES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* sv/lpr_rank_unit.sv */
`timescale 1ns / 1ps
// Valid bits and recency ranks of the frames, with the shared compare and
// increment unit that ages one frame per cycle. Depends on lpr_pkg.
module lpr_rank_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [lpr_pkg::FRAME_W-1:0] idx,
  input  lpr_pkg::rank_ctl_t          ctl,
  output logic                        cur_valid,
  output logic [lpr_pkg::RANK_W-1:0]  cur_rank
);
  import lpr_pkg::*;

  logic [MAX_FRAMES-1:0] valid;
  logic [RANK_W-1:0]     rank [MAX_FRAMES];
  logic                  bump;

  assign cur_valid = valid[idx];
  assign cur_rank  = rank[idx];

  assign bump = cur_valid && (CNT_W'(cur_rank) < ctl.old_rank) &&
                (cur_rank != RANK_W'(MAX_FRAMES - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
        rank[i] <= '0;
      end
    end else begin
      if (ctl.set_valid) begin
        valid[ctl.frame] <= 1'b1;
      end
      if (ctl.touch_en) begin
        if (idx == ctl.frame) begin
          rank[idx] <= '0;
        end else if (bump) begin
          rank[idx] <= cur_rank + RANK_W'(1);
        end
      end
    end
  end

endmodule

/* sv/lru_page_replacement_core.sv */
`timescale 1ns / 1ps
// LRU page replacement core: each frame is examined in turn, in a fetch state and
// then a compare state, by a single comparator on the registered page memory read;
// a hit ends the scan at its frame and a miss scans all active frames before the
// replacement, then ranks age one per cycle. The core returns to idle once the
// result beat is taken, so one reference is taken at a time. Synchronous rst clears
// the valid bits, ranks and fault count and sets frames_in_use to 16.
module lru_page_replacement_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [lpr_pkg::CFG_W-1:0]       cfg_wr_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [lpr_pkg::PAGE_IN_W-1:0]   page_number,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            hit,
  output logic [lpr_pkg::FRAME_OUT_W-1:0] frame_index,
  output logic [lpr_pkg::FAULT_W-1:0]     fault_count
);
  import lpr_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_FETCH  = 6'b000010,
    ST_CMP    = 6'b000100,
    ST_DECIDE = 6'b001000,
    ST_TOUCH  = 6'b010000,
    ST_OUT    = 6'b100000
  } state_t;

  state_t               state;
  logic [CFG_W-1:0]     frames_in_use;
  logic [PAGE_BITS-1:0] page_q;
  logic [CNT_W-1:0]     n_q;
  logic [FRAME_W-1:0]   idx;
  logic                 found;
  logic                 empty_seen;
  logic [FRAME_W-1:0]   empty_idx;
  logic [FRAME_W-1:0]   best_idx;
  logic [RANK_W-1:0]    best_rank;
  logic [FRAME_W-1:0]   frame_q;
  logic [CNT_W-1:0]     old_rank;
  logic [FAULT_W-1:0]   faults_seen;
  logic                 hit_q;
  logic [FRAME_W-1:0]   frame_out_q;
  logic [FAULT_W-1:0]   fault_out_q;

  logic [CNT_W-1:0]     n_clamped;
  logic [FRAME_W-1:0]   victim;
  logic                 last;
  logic                 accept;
  logic                 cur_valid;
  logic [RANK_W-1:0]    cur_rank;
  logic [PAGE_BITS-1:0] rdata;
  logic                 page_match;
  rank_ctl_t            rank_ctl;

  always_comb begin
    if (frames_in_use == '0) begin
      n_clamped = CNT_W'(1);
    end else if (frames_in_use > CFG_W'(MAX_FRAMES)) begin
      n_clamped = CNT_W'(MAX_FRAMES);
    end else begin
      n_clamped = CNT_W'(frames_in_use);
    end
  end

  assign in_stall   = (state != ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign out_valid  = (state == ST_OUT);
  assign victim     = empty_seen ? empty_idx : best_idx;
  assign last       = (CNT_W'(idx) + CNT_W'(1)) == n_q;
  assign page_match = cur_valid && (rdata == page_q);

  assign hit         = hit_q;
  assign frame_index = FRAME_OUT_W'(frame_out_q);
  assign fault_count = fault_out_q;

  always_comb begin
    rank_ctl.touch_en  = (state == ST_TOUCH);
    rank_ctl.set_valid = (state == ST_DECIDE) && empty_seen;
    rank_ctl.frame     = (state == ST_DECIDE) ? victim : frame_q;
    rank_ctl.old_rank  = old_rank;
  end

  lpr_page_mem u_page_mem (
    .clk   (clk),
    .we    (state == ST_DECIDE),
    .waddr (victim),
    .wdata (page_q),
    .raddr (idx),
    .rdata (rdata)
  );

  lpr_rank_unit u_rank_unit (
    .clk       (clk),
    .rst       (rst),
    .idx       (idx),
    .ctl       (rank_ctl),
    .cur_valid (cur_valid),
    .cur_rank  (cur_rank)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= FRAMES_RESET;
    end else if (cfg_wr_en) begin
      frames_in_use <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      faults_seen <= '0;
      idx         <= '0;
      found       <= 1'b0;
      empty_seen  <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            page_q     <= page_number[PAGE_BITS-1:0];
            n_q        <= n_clamped;
            idx        <= '0;
            found      <= 1'b0;
            empty_seen <= 1'b0;
            state      <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          state <= ST_CMP;
        end
        ST_CMP: begin
          if (page_match) begin
            found    <= 1'b1;
            frame_q  <= idx;
            old_rank <= CNT_W'(cur_rank);
            idx      <= '0;
            state    <= ST_TOUCH;
          end else begin
            if (!cur_valid && !empty_seen) begin
              empty_seen <= 1'b1;
              empty_idx  <= idx;
            end
            if (idx == '0 || cur_rank > best_rank) begin
              best_idx  <= idx;
              best_rank <= cur_rank;
            end
            if (last) begin
              state <= ST_DECIDE;
            end else begin
              idx   <= idx + FRAME_W'(1);
              state <= ST_FETCH;
            end
          end
        end
        ST_DECIDE: begin
          frame_q  <= victim;
          old_rank <= empty_seen ? n_q : CNT_W'(best_rank);
          if (faults_seen != '1) begin
            faults_seen <= faults_seen + FAULT_W'(1);
          end
          idx   <= '0;
          state <= ST_TOUCH;
        end
        ST_TOUCH: begin
          if (last) begin
            hit_q       <= found;
            frame_out_q <= frame_q;
            fault_out_q <= faults_seen;
            state       <= ST_OUT;
          end else begin
            idx <= idx + FRAME_W'(1);
          end
        end
        ST_OUT: begin
          if (!out_stall) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_take_while_holding: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("A reference was taken while a result beat was pending.");

  a_faults_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> faults_seen >= $past(faults_seen))
    else $error("The fault counter went backwards.");

  a_frame_active: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT) |-> (CNT_W'(frame_q) < n_q))
    else $error("The reported frame lies outside the active frames.");

  a_decide_only_on_miss: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DECIDE) |-> !found)
    else $error("Replacement was started after a hit.");
`endif

endmodule

/* tb/lru_checker.sv */
`timescale 1ns / 1ps
// Result checker for lru_page_replacement_core: it tracks frame contents, recency
// ranks and the fault total on every accepted beat and compares each result beat.
// Depends on lpr_pkg; instantiated beside the core by tb_top.
module lru_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [lpr_pkg::CFG_W-1:0]       cfg_wr_data,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [lpr_pkg::PAGE_IN_W-1:0]   page_number,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic                            hit,
  input  logic [lpr_pkg::FRAME_OUT_W-1:0] frame_index,
  input  logic [lpr_pkg::FAULT_W-1:0]     fault_count,
  output int                              pending,
  output int                              errors
);
  import lpr_pkg::*;

  typedef struct packed {
    logic                   hit;
    logic [FRAME_OUT_W-1:0] frame;
    logic [FAULT_W-1:0]     faults;
  } lru_result_t;

  logic [CFG_W-1:0]     frames_reg;
  logic [PAGE_BITS-1:0] frame_tag [MAX_FRAMES];
  bit                   frame_live [MAX_FRAMES];
  int                   frame_age [MAX_FRAMES];
  logic [FAULT_W-1:0]   fault_total;
  lru_result_t          expected_results [$];
  lru_result_t          oldest;
  int                   mismatch_total = 0;

  function automatic lru_result_t lru_reference(input logic [PAGE_IN_W-1:0] page_in);
    int                   active;
    int                   slot;
    int                   prior;
    bit                   found;
    bit                   filled;
    logic [PAGE_BITS-1:0] tag;
    lru_result_t          res;
    tag    = page_in[PAGE_BITS-1:0];
    active = (frames_reg == 0) ? 1 : (frames_reg > MAX_FRAMES) ? MAX_FRAMES : frames_reg;
    found  = 1'b0;
    filled = 1'b0;
    slot   = 0;
    prior  = 0;
    for (int i = 0; i < active; i++) begin
      if (!found && frame_live[i] && frame_tag[i] == tag) begin
        slot  = i;
        found = 1'b1;
      end
    end
    if (found) begin
      prior = frame_age[slot];
    end else begin
      for (int i = 0; i < active; i++) begin
        if (!filled && !frame_live[i]) begin
          slot   = i;
          filled = 1'b1;
        end
      end
      if (filled) begin
        frame_live[slot] = 1'b1;
        prior = active;
      end else begin
        slot = 0;
        for (int i = 1; i < active; i++) begin
          if (frame_age[i] > frame_age[slot]) slot = i;
        end
        prior = frame_age[slot];
      end
      frame_tag[slot] = tag;
      if (fault_total != '1) fault_total = fault_total + 1'b1;
    end
    for (int j = 0; j < active; j++) begin
      if (j != slot && frame_live[j] && frame_age[j] < prior && frame_age[j] < MAX_FRAMES - 1)
        frame_age[j] = frame_age[j] + 1;
    end
    frame_age[slot] = 0;
    res.hit    = found;
    res.frame  = slot[FRAME_OUT_W-1:0];
    res.faults = fault_total;
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      frames_reg  = FRAMES_RESET;
      fault_total = '0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
        frame_live[i] = 1'b0;
        frame_age[i]  = 0;
      end
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result beat with nothing expected, got hit %0d frame %0d faults %0d",
                   $time, hit, frame_index, fault_count);
          mismatch_total++;
        end else begin
          oldest = expected_results.pop_front();
          if (hit !== oldest.hit) begin
            $display("%0t: hit expected %0d, actual %0d", $time, oldest.hit, hit);
            mismatch_total++;
          end
          if (frame_index !== oldest.frame) begin
            $display("%0t: frame_index expected %0d, actual %0d", $time, oldest.frame,
                     frame_index);
            mismatch_total++;
          end
          if (fault_count !== oldest.faults) begin
            $display("%0t: fault_count expected %0d, actual %0d", $time, oldest.faults,
                     fault_count);
            mismatch_total++;
          end
        end
      end
      if (in_valid && !in_stall) expected_results.push_back(lru_reference(page_number));
      if (cfg_wr_en) frames_reg = cfg_wr_data;
    end
    pending <= expected_results.size();
    errors  <= mismatch_total;
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Top of the LRU page replacement testbench: clock, reset, page reference
// stimulus, frame count settings and the verdict. Depends on lpr_pkg,
// lru_page_replacement_core and lru_checker.
module tb_top;
  import lpr_pkg::*;

  logic                   clk;
  logic                   rst;
  logic                   cfg_wr_en;
  logic [CFG_W-1:0]       cfg_wr_data;
  logic                   in_valid;
  logic                   in_stall;
  logic [PAGE_IN_W-1:0]   page_number;
  logic                   out_valid;
  logic                   out_stall;
  logic                   hit;
  logic [FRAME_OUT_W-1:0] frame_index;
  logic [FAULT_W-1:0]     fault_count;
  int                     pending;
  int                     errors;

  int                     gap_odds = 0;
  int                     stall_odds = 0;
  int                     stall_left = 0;
  int                     refs_sent = 0;
  int                     active;
  logic [CFG_W-1:0]       setting;
  logic [PAGE_IN_W-1:0]   pg;
  logic [PAGE_IN_W-1:0]   hot_pages [$];

  lru_page_replacement_core dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .page_number (page_number),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hit         (hit),
    .frame_index (frame_index),
    .fault_count (fault_count)
  );

  lru_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .page_number (page_number),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hit         (hit),
    .frame_index (frame_index),
    .fault_count (fault_count),
    .pending     (pending),
    .errors      (errors)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (!out_stall && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
      stall_left = $urandom_range(0, 4);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic reference_page(input logic [PAGE_IN_W-1:0] page_in);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    page_number <= page_in;
    do @(posedge clk); while (in_stall);
    refs_sent++;
  endtask

  task automatic write_frames(input logic [CFG_W-1:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    rst         <= 1'b1;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_valid    <= 1'b0;
    page_number <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Page 0 must fault on a fresh core even though the frames hold nothing.
    stall_odds = 4;
    reference_page(16'h0000);
    reference_page(16'hFFFF);
    reference_page(16'h0000);
    reference_page(16'h5555);
    reference_page(16'hAAAA);
    reference_page(16'h0001);
    reference_page(16'h8000);
    // Shrinking hides frames 2 and up, so the same page lands in a low frame
    // as well; after growing again the lowest copy must be the one hit.
    write_frames(5'd2);
    reference_page(16'h5555);
    reference_page(16'h1234);
    reference_page(16'h5555);
    write_frames(5'd31);
    reference_page(16'h5555);
    reference_page(16'hAAAA);
    for (int i = 0; i < 10; i++) reference_page(PAGE_IN_W'(16'h0100 + i));
    reference_page(16'h7FFF);
    reference_page(16'hFFFE);
    write_frames(5'd0);
    reference_page(16'h4321);
    reference_page(16'hFFFF);

    while (refs_sent < 970) begin
      case ($urandom_range(0, 7))
        0: begin
          if ($urandom_range(0, 1) == 0) setting = '0;
          else setting = CFG_W'($urandom_range(17, 31));
        end
        1: setting = 5'd16;
        default: setting = CFG_W'($urandom_range(1, 16));
      endcase
      write_frames(setting);
      active = (setting == 0) ? 1 : (setting > MAX_FRAMES) ? MAX_FRAMES : setting;
      hot_pages.delete();
      repeat ($urandom_range(1, active + 4))
        hot_pages.push_back(PAGE_IN_W'($urandom_range(0, 65535)));
      gap_odds   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 6);
      stall_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 6);
      repeat ($urandom_range(15, 60)) begin
        if ($urandom_range(0, 99) < 85) pg = hot_pages[$urandom_range(0, hot_pages.size() - 1)];
        else pg = PAGE_IN_W'($urandom_range(0, 65535));
        reference_page(pg);
      end
    end

    gap_odds   = 0;
    stall_odds = 0;
    write_frames(5'd16);
    hot_pages.delete();
    repeat (20) hot_pages.push_back(PAGE_IN_W'($urandom_range(0, 65535)));
    repeat (80) reference_page(hot_pages[$urandom_range(0, hot_pages.size() - 1)]);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
